FILE: sv/chls_pkg.sv
// Shared types and constants of the Cholesky linear solver.
// Holds the controller-to-datapath command and status structs.
// Depends on nothing; the datapath, controller, top level and testbench import it.
package chls_pkg;

  // Default build values and the fixed result limit.
  localparam int MAX_ORDER_DEF = 16;
  localparam int FRAC_BITS_DEF = 16;
  localparam int RESULT_LIMIT  = 16;

  // Loop counters hold 0 .. RESULT_LIMIT.
  localparam int CW = 5;

  // Register map: word index of each configuration register.
  localparam int         REG_SIZE_IN_USE = 0;
  localparam logic [4:0] SIZE_RESET      = 5'd16;

  // Kind of element that the datapath is working on.
  typedef enum logic [1:0] {
    OP_DIAG = 2'd0,  // pivot G[j][j]
    OP_OFF  = 2'd1,  // off-diagonal G[i][j]
    OP_FWD  = 2'd2,  // forward substitution y[i]
    OP_BWD  = 2'd3   // back substitution x[i]
  } op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    op_t           op;
    logic [CW-1:0] i;
    logic [CW-1:0] j;
    logic [CW-1:0] k;
    logic [CW-1:0] e;
    logic          load;
    logic          clr_flags;
    logic          clr_acc;
    logic          mac_rd;
    logic          mul;
    logic          acc;
    logic          base_rd;
    logic          base;
    logic          unit_start;
    logic          wr;
    logic          emit_rd;
    logic          emit;
    logic          last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;
  } status_t;

endpackage

FILE: sv/chls_sqrt.sv
// Iterative integer square root, two radicand bits per cycle.
// Used by the datapath to form each pivot; uses no package items.
module chls_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  localparam logic [4:0] LAST_STEP = 5'd31;

  logic [63:0] rad;
  logic [33:0] rem;
  logic [33:0] rem_sh;
  logic [33:0] trial;
  logic [4:0]  cnt;
  logic        run;
  logic        fits;

  // Trial subtraction of the next root bit.
  always_comb begin
    rem_sh = {rem[31:0], rad[63:62]};
    trial  = {root, 2'b01};
    fits   = (rem_sh >= trial);
  end

  // One result bit per cycle, most significant first.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
      end else if (run) begin
        rad <= {rad[61:0], 2'b00};
        if (fits) begin
          rem  <= rem_sh - trial;
          root <= {root[30:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[30:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == LAST_STEP) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: sv/chls_div.sv
// Iterative unsigned 64 by 32 bit restoring divider, one quotient bit per cycle.
// Used by the datapath for every division by a pivot; uses no package items.
module chls_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  localparam logic [5:0] LAST_STEP = 6'd63;

  logic [32:0] rem;
  logic [32:0] rem_sh;
  logic [31:0] den;
  logic [5:0]  cnt;
  logic        run;
  logic        fits;

  // Shift in the next dividend bit and test the divisor against it.
  always_comb begin
    rem_sh = {rem[31:0], quotient[63]};
    fits   = (rem_sh >= {1'b0, den});
  end

  // The quotient bits shift in where the dividend bits leave.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run      <= 1'b1;
        quotient <= dividend;
        den      <= divisor;
        rem      <= '0;
        cnt      <= '0;
      end else if (run) begin
        rem      <= fits ? (rem_sh - {1'b0, den}) : rem_sh;
        quotient <= {quotient[62:0], fits};
        cnt      <= cnt + 6'd1;
        if (cnt == LAST_STEP) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: sv/chls_dp.sv
// Datapath of the Cholesky linear solver: stores, multiplier, accumulator,
// square root and divider units, result registers.
// Depends on chls_pkg, chls_sqrt and chls_div.
module chls_dp #(
  parameter int MAX_ORDER = chls_pkg::MAX_ORDER_DEF,
  parameter int FRAC_BITS = chls_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  chls_pkg::cmd_t      cmd,
  output chls_pkg::status_t   status,
  input  logic                action,
  input  logic [3:0]          row,
  input  logic [3:0]          col,
  input  logic signed [31:0]  value,
  output logic                done,
  output logic [3:0]          index,
  output logic signed [31:0]  solution,
  output logic                not_positive_definite,
  output logic                overflow,
  output logic                last
);
  import chls_pkg::*;

  localparam int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam logic signed [31:0] I32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] I32_MIN = 32'sh8000_0000;
  localparam logic signed [63:0] I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] I64_MIN = 64'sh8000_0000_0000_0000;

  // Stores: A, G and the vectors b, y, x.
  logic signed [31:0] a_mem [MAX_ORDER][MAX_ORDER];
  logic signed [31:0] g_mem [MAX_ORDER][MAX_ORDER];
  logic signed [31:0] b_mem [MAX_ORDER];
  logic signed [31:0] y_mem [MAX_ORDER];
  logic signed [31:0] x_mem [MAX_ORDER];

  logic signed [31:0] a_q, ga_q, gb_q, b_q, y_q, x_q;
  logic [IW-1:0] ri, rj, rk, re;
  logic [IW-1:0] ga_r, ga_c, gb_r, gb_c, y_a, x_a;
  logic          rd_en, in_ok, a_we, b_we, g_we, y_we, x_we;

  logic signed [31:0] q_val, base_val, piv, res;
  logic signed [63:0] prod, acc, dval, wide;
  logic signed [64:0] acc_sum, diff;
  logic               npd, ov, neg, skip_done;

  logic        sq_start, sq_done, dv_start, dv_done;
  logic [31:0] sq_root;
  logic [63:0] dv_quot, dv_num;

  // Index decode and store addresses for the element in work.
  always_comb begin
    ri = IW'(cmd.i);
    rj = IW'(cmd.j);
    rk = IW'(cmd.k);
    re = IW'(cmd.e);
    if (cmd.op == OP_BWD) begin
      ga_r = rk;
      ga_c = ri;
    end else if (cmd.op == OP_DIAG) begin
      ga_r = rj;
      ga_c = rk;
    end else begin
      ga_r = ri;
      ga_c = rk;
    end
    if (cmd.base_rd) begin
      gb_r = (cmd.op == OP_OFF) ? rj : ri;
      gb_c = gb_r;
    end else begin
      gb_r = rj;
      gb_c = rk;
    end
    y_a   = (cmd.op == OP_BWD) ? ri : rk;
    x_a   = cmd.emit_rd ? re : rk;
    rd_en = cmd.mac_rd | cmd.base_rd | cmd.emit_rd;
    in_ok = (int'(row) < MAX_ORDER);
    a_we  = cmd.load & ~action & in_ok & (int'(col) < MAX_ORDER);
    b_we  = cmd.load & action & in_ok;
    g_we  = cmd.wr & ((cmd.op == OP_DIAG) | (cmd.op == OP_OFF));
    y_we  = cmd.wr & (cmd.op == OP_FWD);
    x_we  = cmd.wr & (cmd.op == OP_BWD);
  end

  // Matrix store: written by requests, read for the base term.
  always_ff @(posedge clk) begin
    if (a_we) a_mem[IW'(row)][IW'(col)] <= value;
    if (rd_en) a_q <= a_mem[ri][rj];
  end

  // Factor store: one write port, two read ports.
  always_ff @(posedge clk) begin
    if (g_we) g_mem[ri][rj] <= res;
    if (rd_en) begin
      ga_q <= g_mem[ga_r][ga_c];
      gb_q <= g_mem[gb_r][gb_c];
    end
  end

  // Vector stores.
  always_ff @(posedge clk) begin
    if (b_we) b_mem[IW'(row)] <= value;
    if (y_we) y_mem[ri] <= res;
    if (x_we) x_mem[ri] <= res;
    if (rd_en) begin
      b_q <= b_mem[ri];
      y_q <= y_mem[y_a];
      x_q <= x_mem[x_a];
    end
  end

  // Operand selection, saturating sums and the widened base term.
  always_comb begin
    if ((cmd.op == OP_DIAG) || (cmd.op == OP_OFF)) begin
      q_val    = gb_q;
      base_val = a_q;
    end else if (cmd.op == OP_FWD) begin
      q_val    = y_q;
      base_val = b_q;
    end else begin
      q_val    = x_q;
      base_val = y_q;
    end
    wide    = $signed(64'(base_val)) <<< FRAC_BITS;
    acc_sum = {acc[63], acc} + {prod[63], prod};
    diff    = {wide[63], wide} - {acc[63], acc};
    dv_num  = dval[63] ? (64'd0 - dval) : dval;
    sq_start = cmd.unit_start & (cmd.op == OP_DIAG) & (dval > 64'sd0);
    dv_start = cmd.unit_start & (cmd.op != OP_DIAG) & (piv > 32'sd0);
  end

  chls_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (dval),
    .done     (sq_done),
    .root     (sq_root)
  );

  chls_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (dv_start),
    .dividend (dv_num),
    .divisor  (piv),
    .done     (dv_done),
    .quotient (dv_quot)
  );

  assign status.done = sq_done | dv_done | skip_done;

  // Arithmetic registers and the error flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      npd       <= 1'b0;
      ov        <= 1'b0;
      skip_done <= 1'b0;
    end else begin
      skip_done <= 1'b0;
      if (cmd.clr_flags) begin
        npd <= 1'b0;
        ov  <= 1'b0;
      end
      if (cmd.clr_acc) acc <= '0;
      if (cmd.mul) prod <= ga_q * q_val;
      // Saturating accumulation of one product.
      if (cmd.acc) begin
        if (acc_sum[64] != acc_sum[63]) begin
          acc <= acc_sum[64] ? I64_MIN : I64_MAX;
          ov  <= 1'b1;
        end else begin
          acc <= acc_sum[63:0];
        end
      end
      // Base term minus the accumulated sum, and the pivot.
      if (cmd.base) begin
        piv <= gb_q;
        if (diff[64] != diff[63]) begin
          dval <= diff[64] ? I64_MIN : I64_MAX;
          ov   <= 1'b1;
        end else begin
          dval <= diff[63:0];
        end
      end
      // Cases that need neither unit.
      if (cmd.unit_start) begin
        neg <= dval[63];
        if ((cmd.op == OP_DIAG) && (dval <= 64'sd0)) begin
          res       <= '0;
          npd       <= 1'b1;
          skip_done <= 1'b1;
        end else if ((cmd.op != OP_DIAG) && (piv <= 32'sd0)) begin
          res       <= '0;
          skip_done <= 1'b1;
        end
      end
      // Pivot clipped to the signed range.
      if (sq_done) begin
        if (sq_root[31]) begin
          res <= I32_MAX;
          ov  <= 1'b1;
        end else begin
          res <= $signed(sq_root);
        end
      end
      // Quotient truncated toward zero and clipped.
      if (dv_done) begin
        if (!neg && (dv_quot > 64'h0000_0000_7FFF_FFFF)) begin
          res <= I32_MAX;
          ov  <= 1'b1;
        end else if (neg && (dv_quot > 64'h0000_0000_8000_0000)) begin
          res <= I32_MIN;
          ov  <= 1'b1;
        end else if (neg) begin
          res <= $signed(32'd0 - dv_quot[31:0]);
        end else begin
          res <= $signed(dv_quot[31:0]);
        end
      end
    end
  end

  // Result registers: one strobe per unknown.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
    if (cmd.emit) begin
      index                 <= 4'(cmd.e);
      solution              <= x_q;
      not_positive_definite <= npd;
      overflow              <= ov;
      last                  <= cmd.last;
    end
  end

endmodule

FILE: sv/chls_ctrl.sv
// Controller of the Cholesky linear solver: sequences factoring, both
// substitutions and the output of the unknowns. Depends on chls_pkg.
module chls_ctrl #(
  parameter int MAX_ORDER = chls_pkg::MAX_ORDER_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              start_solve,
  input  logic [4:0]        size_in_use,
  input  chls_pkg::status_t status,
  output logic              busy,
  output chls_pkg::cmd_t    cmd
);
  import chls_pkg::*;

  localparam int LIMIT = (MAX_ORDER < RESULT_LIMIT) ? MAX_ORDER : RESULT_LIMIT;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_OPEN  = 12'b0000_0000_0010,
    S_RD    = 12'b0000_0000_0100,
    S_MUL   = 12'b0000_0000_1000,
    S_ACC   = 12'b0000_0001_0000,
    S_BRD   = 12'b0000_0010_0000,
    S_BASE  = 12'b0000_0100_0000,
    S_UST   = 12'b0000_1000_0000,
    S_UWAIT = 12'b0001_0000_0000,
    S_WR    = 12'b0010_0000_0000,
    S_ERD   = 12'b0100_0000_0000,
    S_EOUT  = 12'b1000_0000_0000
  } state_t;

  state_t        state, state_next;
  op_t           op, op_next;
  logic [CW-1:0] n, n_next, i, i_next, j, j_next, k, k_next, e, e_next;
  logic [CW-1:0] n_calc, kstart, kend;

  // Order in use, and the bounds of the running dot product.
  always_comb begin
    if (size_in_use == '0) begin
      n_calc = CW'(1);
    end else if (size_in_use > CW'(LIMIT)) begin
      n_calc = CW'(LIMIT);
    end else begin
      n_calc = size_in_use;
    end
    kstart = (op == OP_BWD) ? (i + CW'(1)) : '0;
    if (op == OP_BWD) begin
      kend = n;
    end else if ((op == OP_DIAG) || (op == OP_OFF)) begin
      kend = j;
    end else begin
      kend = i;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    op_next    = op;
    n_next     = n;
    i_next     = i;
    j_next     = j;
    k_next     = k;
    e_next     = e;
    cmd        = '0;
    cmd.op     = op;
    cmd.i      = i;
    cmd.j      = j;
    cmd.k      = k;
    cmd.e      = e;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (start_solve) begin
            cmd.clr_flags = 1'b1;
            n_next        = n_calc;
            op_next       = OP_DIAG;
            i_next        = '0;
            j_next        = '0;
            state_next    = S_OPEN;
          end
        end
      end
      S_OPEN: begin
        cmd.clr_acc = 1'b1;
        k_next      = kstart;
        state_next  = S_RD;
      end
      S_RD: begin
        if (k < kend) begin
          cmd.mac_rd = 1'b1;
          state_next = S_MUL;
        end else begin
          state_next = S_BRD;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        k_next     = k + CW'(1);
        state_next = S_RD;
      end
      S_BRD: begin
        cmd.base_rd = 1'b1;
        state_next  = S_BASE;
      end
      S_BASE: begin
        cmd.base   = 1'b1;
        state_next = S_UST;
      end
      S_UST: begin
        cmd.unit_start = 1'b1;
        state_next     = S_UWAIT;
      end
      S_UWAIT: begin
        if (status.done) state_next = S_WR;
      end
      // Store the element and step to the next one.
      S_WR: begin
        cmd.wr     = 1'b1;
        state_next = S_OPEN;
        unique case (op)
          OP_DIAG: begin
            if (j + CW'(1) < n) begin
              op_next = OP_OFF;
              i_next  = j + CW'(1);
            end else begin
              op_next = OP_FWD;
              i_next  = '0;
            end
          end
          OP_OFF: begin
            if (i + CW'(1) < n) begin
              i_next = i + CW'(1);
            end else begin
              op_next = OP_DIAG;
              j_next  = j + CW'(1);
              i_next  = j + CW'(1);
            end
          end
          OP_FWD: begin
            if (i + CW'(1) < n) begin
              i_next = i + CW'(1);
            end else begin
              op_next = OP_BWD;
              i_next  = n - CW'(1);
            end
          end
          OP_BWD: begin
            if (i == '0) begin
              e_next     = '0;
              state_next = S_ERD;
            end else begin
              i_next = i - CW'(1);
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_ERD: begin
        cmd.emit_rd = 1'b1;
        state_next  = S_EOUT;
      end
      S_EOUT: begin
        cmd.emit = 1'b1;
        cmd.last = (e == n - CW'(1));
        if (e == n - CW'(1)) begin
          state_next = S_IDLE;
        end else begin
          e_next     = e + CW'(1);
          state_next = S_ERD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

  // State and loop counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_DIAG;
      n     <= CW'(1);
      i     <= '0;
      j     <= '0;
      k     <= '0;
      e     <= '0;
    end else begin
      state <= state_next;
      op    <= op_next;
      n     <= n_next;
      i     <= i_next;
      j     <= j_next;
      k     <= k_next;
      e     <= e_next;
    end
  end

endmodule

FILE: sv/cholesky_linear_solver_top.sv
// Top level of the Cholesky linear solver: configuration port, controller
// and datapath. Depends on chls_pkg, chls_ctrl and chls_dp.
//
// Each request without start_solve stores one entry of A or b and is taken in
// the idle state without raising busy. The request with start_solve is stored
// and then the solve runs with busy high: every product term of a dot product
// passes the read, multiply and accumulate states, each element then the base
// read, base, unit start, wait and write states. A pivot is formed in the
// square root unit and every other element in the shared divider, each skipped
// when its radicand or pivot is not positive; the solve time is governed by the
// divider and the single multiply-accumulate loop. The unknowns then leave in
// order of index, each on the result ports for one cycle while done is high;
// they cannot be held off. busy falls as the last one is produced.
module cholesky_linear_solver_top #(
  parameter int MAX_ORDER = chls_pkg::MAX_ORDER_DEF,
  parameter int FRAC_BITS = chls_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic               action,
  input  logic [3:0]         row,
  input  logic [3:0]         col,
  input  logic signed [31:0] value,
  input  logic               start_solve,
  output logic               done,
  output logic [3:0]         index,
  output logic signed [31:0] solution,
  output logic               not_positive_definite,
  output logic               overflow,
  output logic               last
);
  import chls_pkg::*;

  logic [4:0] size_in_use;
  logic       reg_hit;
  cmd_t       cmd;
  status_t    status;

  // Configuration register.
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == 1'(REG_SIZE_IN_USE));
  assign prdata  = reg_hit ? {27'd0, size_in_use} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= SIZE_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      size_in_use <= pwdata[4:0];
    end
  end

  chls_ctrl #(.MAX_ORDER(MAX_ORDER)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .start_solve (start_solve),
    .size_in_use (size_in_use),
    .status      (status),
    .busy        (busy),
    .cmd         (cmd)
  );

  chls_dp #(.MAX_ORDER(MAX_ORDER), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk                   (clk),
    .rst                   (rst),
    .cmd                   (cmd),
    .status                (status),
    .action                (action),
    .row                   (row),
    .col                   (col),
    .value                 (value),
    .done                  (done),
    .index                 (index),
    .solution              (solution),
    .not_positive_definite (not_positive_definite),
    .overflow              (overflow),
    .last                  (last)
  );

endmodule

FILE: sv/chls_checker.sv
// Port-level checks of the Cholesky linear solver and their binding.
// Depends only on the ports of cholesky_linear_solver_top.
module chls_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       start_solve,
  input logic       busy,
  input logic       done,
  input logic [3:0] index,
  input logic       last,
  input logic       not_positive_definite
);

  // A request that starts a solve makes the block busy.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && start_solve) |=> busy)
    else $error("solve request did not raise busy");

  // After each unknown but the last, done drops and then rises again for the next one.
  assert property (@(posedge clk) disable iff (rst)
    (done && !last) |=> (!done ##1 done))
    else $error("result spacing broken");

  // Indices of consecutive unknowns count up.
  assert property (@(posedge clk) disable iff (rst)
    (done && !last) |=> ##1 (index == $past(index, 2) + 4'd1))
    else $error("result index did not advance");

  // The error flag stays the same within one solve.
  assert property (@(posedge clk) disable iff (rst)
    (done && !last) |=> ##1 (not_positive_definite == $past(not_positive_definite, 2)))
    else $error("error flag changed within a solve");

endmodule

bind cholesky_linear_solver_top chls_checker u_chls_checker (
  .clk                   (clk),
  .rst                   (rst),
  .start                 (start),
  .start_solve           (start_solve),
  .busy                  (busy),
  .done                  (done),
  .index                 (index),
  .last                  (last),
  .not_positive_definite (not_positive_definite)
);

FILE: bench/cholesky_linear_solver_top_tb.sv
// Self-checking testbench for the Cholesky linear solver top level.
// Depends on chls_pkg and the cholesky_linear_solver_top RTL; a directed table
// of requests is followed by random systems, checked by a local predictor or table values.
module cholesky_linear_solver_top_tb;
  import chls_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int     N_MAX      = 16;
  localparam int     ONE        = 65536;
  localparam int     CYCLE_CAP  = 1500000;
  localparam int     RAND_ITEMS = 150;
  localparam longint I64_MAX    = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint I64_MIN    = -I64_MAX - 1;
  localparam int     I32_MAX    = 32'sh7FFF_FFFF;
  localparam int     I32_MIN    = 32'sh8000_0000;

  // Load kinds carried on the action port.
  localparam logic ACT_MATRIX = 1'b0;
  localparam logic ACT_RHS    = 1'b1;

  typedef struct {
    logic       action;
    logic [3:0] row;
    logic [3:0] col;
    int         value;
    logic       start_solve;
  } load_req_t;

  typedef struct {
    logic [3:0] index;
    int         solution;
    logic       npd;
    logic       ovf;
    logic       last;
  } unknown_t;

  typedef struct {
    load_req_t  req;
    logic [4:0] size;
    bit         typed;
    int         x0;
    logic       npd;
    logic       ovf;
  } table_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               start = 1'b0;
  logic               busy;
  logic               action = 1'b0;
  logic [3:0]         row = '0, col = '0;
  logic signed [31:0] value = '0;
  logic               start_solve = 1'b0;
  logic               done;
  logic [3:0]         index;
  logic signed [31:0] solution;
  logic               not_positive_definite, overflow, last;

  cholesky_linear_solver_top dut (.*);

  always #5 clk = ~clk;

  // Predictor state and the unknowns still awaited.
  int         a_mem [N_MAX][N_MAX];
  int         b_mem [N_MAX];
  int         g_mem [N_MAX][N_MAX];
  int         y_mem [N_MAX];
  logic [4:0] size_reg = SIZE_RESET;
  unknown_t   pending_x [$];
  int         fail_count = 0;
  int         cycle_count = 0;
  int         burst_left = 0;

  function automatic longint sat_add(longint a, longint b, inout bit ov);
    if (b > 0 && a > I64_MAX - b) begin ov = 1; return I64_MAX; end
    if (b < 0 && a < I64_MIN - b) begin ov = 1; return I64_MIN; end
    return a + b;
  endfunction

  function automatic longint sat_sub(longint a, longint b, inout bit ov);
    if (b < 0 && a > I64_MAX + b) begin ov = 1; return I64_MAX; end
    if (b > 0 && a < I64_MIN + b) begin ov = 1; return I64_MIN; end
    return a - b;
  endfunction

  function automatic int clip(longint v, inout bit ov);
    if (v > longint'(I32_MAX)) begin ov = 1; return I32_MAX; end
    if (v < longint'(I32_MIN)) begin ov = 1; return I32_MIN; end
    return int'(v);
  endfunction

  function automatic int quot(longint num, int piv, inout bit ov);
    if (piv <= 0) return 0;
    return clip(num / longint'(piv), ov);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned d);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > d) b >>= 2;
    while (b != 0) begin
      if (d >= r + b) begin
        d -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic int order_of(logic [4:0] s);
    if (s == 0) return 1;
    if (s > N_MAX) return N_MAX;
    return int'(s);
  endfunction

  // Factor, substitute both ways and queue the unknowns of the solve.
  function automatic void solve_system(bit typed, int tx, logic tnpd, logic tovf);
    bit              ov, npd;
    int              n, piv;
    int              xs [N_MAX];
    longint          acc, d, s;
    longint unsigned r;
    unknown_t        u;
    ov = 0; npd = 0;
    n = order_of(size_reg);
    for (int j = 0; j < n; j++) begin
      acc = 0;
      piv = 0;
      for (int k = 0; k < j; k++)
        acc = sat_add(acc, longint'(g_mem[j][k]) * longint'(g_mem[j][k]), ov);
      d = sat_sub(longint'(a_mem[j][j]) * ONE, acc, ov);
      if (d > 0) begin
        r = root_floor(longint'(d));
        if (r > 64'd2147483647) begin ov = 1; r = 64'd2147483647; end
        piv = int'(r);
      end
      if (piv <= 0) begin npd = 1; piv = 0; end
      g_mem[j][j] = piv;
      for (int i = j + 1; i < n; i++) begin
        s = 0;
        for (int k = 0; k < j; k++)
          s = sat_add(s, longint'(g_mem[i][k]) * longint'(g_mem[j][k]), ov);
        s = sat_sub(longint'(a_mem[i][j]) * ONE, s, ov);
        g_mem[i][j] = quot(s, piv, ov);
      end
    end
    for (int i = 0; i < n; i++) begin
      s = 0;
      for (int k = 0; k < i; k++)
        s = sat_add(s, longint'(g_mem[i][k]) * longint'(y_mem[k]), ov);
      s = sat_sub(longint'(b_mem[i]) * ONE, s, ov);
      y_mem[i] = quot(s, g_mem[i][i], ov);
    end
    for (int i = n - 1; i >= 0; i--) begin
      s = 0;
      for (int k = i + 1; k < n; k++)
        s = sat_add(s, longint'(g_mem[k][i]) * longint'(xs[k]), ov);
      s = sat_sub(longint'(y_mem[i]) * ONE, s, ov);
      xs[i] = quot(s, g_mem[i][i], ov);
    end
    for (int i = 0; i < n; i++) begin
      u.index    = 4'(i);
      u.solution = typed ? tx : xs[i];
      u.npd      = typed ? tnpd : npd;
      u.ovf      = typed ? tovf : ov;
      u.last     = (i == n - 1);
      pending_x.push_back(u);
    end
  endfunction

  // Store the entry; a request carrying start_solve then runs the solve.
  function automatic void predict_request(load_req_t q, bit typed, int tx,
                                          logic tnpd, logic tovf);
    if (q.action == ACT_MATRIX) a_mem[q.row][q.col] = q.value;
    else b_mem[q.row] = q.value;
    if (q.start_solve) solve_system(typed, tx, tnpd, tovf);
  endfunction

  // Present one request, in bursts with random gaps, and wait for it to be taken.
  task automatic send_request(load_req_t q, bit typed = 0, int tx = 0,
                              logic tnpd = 0, logic tovf = 0);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    start       <= 1'b1;
    action      <= q.action;
    row         <= q.row;
    col         <= q.col;
    value       <= q.value;
    start_solve <= q.start_solve;
    do @(posedge clk); while (busy);
    predict_request(q, typed, tx, tnpd, tovf);
  endtask

  // Write the size register once the block is idle.
  task automatic write_size(logic [4:0] s);
    start <= 1'b0;
    @(posedge clk);
    while (pending_x.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(REG_SIZE_IN_USE * 4);
    pwdata  <= 32'(s);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    size_reg = s;
    burst_left = 0;
  endtask

  function automatic load_req_t mk_req(logic act, int r, int c, int v, logic st);
    load_req_t q;
    q.action = act;
    q.row = 4'(r);
    q.col = 4'(c);
    q.value = v;
    q.start_solve = st;
    return q;
  endfunction

  function automatic table_row_t mk_row(logic [4:0] sz, logic act, int r, int c,
                                        int v, logic st, bit typed = 0,
                                        int x = 0, logic npd = 0, logic ovf = 0);
    table_row_t t;
    t.req = mk_req(act, r, c, v, st);
    t.size = sz;
    t.typed = typed;
    t.x0 = x;
    t.npd = npd;
    t.ovf = ovf;
    return t;
  endfunction

  // Result checker: the block cannot hold results off.
  always @(posedge clk) begin
    unknown_t e;
    if (!rst && done) begin
      if (pending_x.size() == 0) begin
        $error("unexpected result index %0d solution %0d", index, solution);
        fail_count++;
      end else begin
        e = pending_x.pop_front();
        if (index !== e.index) begin
          $error("index: expected %0d, actual %0d", e.index, index); fail_count++;
        end
        if (solution !== e.solution) begin
          $error("solution: expected %0d, actual %0d", e.solution, solution);
          fail_count++;
        end
        if (not_positive_definite !== e.npd) begin
          $error("not_positive_definite: expected %0b, actual %0b", e.npd,
                 not_positive_definite);
          fail_count++;
        end
        if (overflow !== e.ovf) begin
          $error("overflow: expected %0b, actual %0b", e.ovf, overflow); fail_count++;
        end
        if (last !== e.last) begin
          $error("last: expected %0b, actual %0b", e.last, last); fail_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    table_row_t dir_tab [$];
    load_req_t  sys [$];
    load_req_t  tmp;
    int         sent, n, pick, v;
    bit         wild;
    logic [4:0] sz;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Order one: unit pivot, zero and negative pivots, extremes of the values.
    dir_tab.push_back(mk_row(5'd1, ACT_MATRIX, 0, 0, ONE, 0));
    dir_tab.push_back(mk_row(5'd1, ACT_RHS, 0, 9, 2 * ONE, 1, 1, 2 * ONE, 0, 0));
    dir_tab.push_back(mk_row(5'd1, ACT_MATRIX, 0, 0, 0, 1, 1, 0, 1, 0));
    dir_tab.push_back(mk_row(5'd1, ACT_MATRIX, 0, 0, -ONE, 1, 1, 0, 1, 0));
    dir_tab.push_back(mk_row(5'd1, ACT_MATRIX, 0, 0, ONE, 0));
    dir_tab.push_back(mk_row(5'd1, ACT_RHS, 0, 15, I32_MAX, 1, 1, I32_MAX, 0, 0));
    dir_tab.push_back(mk_row(5'd1, ACT_RHS, 0, 0, I32_MIN, 1, 1, I32_MIN, 0, 0));
    // The smallest positive pivot makes the quotients clip.
    dir_tab.push_back(mk_row(5'd1, ACT_MATRIX, 0, 0, 1, 0));
    dir_tab.push_back(mk_row(5'd1, ACT_RHS, 0, 0, I32_MAX, 1, 1, I32_MAX, 0, 1));
    dir_tab.push_back(mk_row(5'd1, ACT_MATRIX, 0, 0, I32_MAX, 1));
    // A size of zero acts as one.
    dir_tab.push_back(mk_row(5'd0, ACT_MATRIX, 0, 0, ONE, 0));
    dir_tab.push_back(mk_row(5'd0, ACT_RHS, 0, 0, ONE, 1, 1, ONE, 0, 0));
    // Order two with an ignored upper-triangle entry.
    dir_tab.push_back(mk_row(5'd2, ACT_MATRIX, 0, 0, 4 * ONE, 0));
    dir_tab.push_back(mk_row(5'd2, ACT_MATRIX, 1, 0, 2 * ONE, 0));
    dir_tab.push_back(mk_row(5'd2, ACT_MATRIX, 1, 1, 5 * ONE, 0));
    dir_tab.push_back(mk_row(5'd2, ACT_MATRIX, 0, 1, 32'h5A5A_A5A5, 0));
    dir_tab.push_back(mk_row(5'd2, ACT_RHS, 0, 0, 6 * ONE, 0));
    dir_tab.push_back(mk_row(5'd2, ACT_RHS, 1, 0, -7 * ONE, 1));
    // Order three that is not positive definite: the second pivot collapses.
    dir_tab.push_back(mk_row(5'd3, ACT_MATRIX, 1, 0, 2 * ONE, 0));
    dir_tab.push_back(mk_row(5'd3, ACT_MATRIX, 1, 1, ONE, 0));
    dir_tab.push_back(mk_row(5'd3, ACT_MATRIX, 2, 0, ONE, 0));
    dir_tab.push_back(mk_row(5'd3, ACT_MATRIX, 2, 1, -ONE, 0));
    dir_tab.push_back(mk_row(5'd3, ACT_MATRIX, 2, 2, 3 * ONE, 0));
    dir_tab.push_back(mk_row(5'd3, ACT_RHS, 2, 3, ONE, 1));

    foreach (dir_tab[i]) begin
      if (dir_tab[i].size != size_reg) write_size(dir_tab[i].size);
      send_request(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].x0,
                   dir_tab[i].npd, dir_tab[i].ovf);
    end

    // Random systems: mostly diagonally dominant, some with wild content.
    sent = 0;
    while (sent < RAND_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       sz = 5'(N_MAX + $urandom_range(0, 15));
        1:       sz = 5'd0;
        2:       sz = 5'd16;
        default: sz = 5'($urandom_range(1, 6));
      endcase
      if (sz != size_reg || $urandom_range(0, 3) == 0) write_size(sz);
      n = order_of(sz);
      wild = ($urandom_range(0, 4) == 0);
      sys.delete();
      for (int i = 0; i < n; i++) begin
        for (int j = 0; j <= i; j++) begin
          if (wild) v = int'($urandom);
          else if (i == j) v = (n + 1) * ONE + int'($urandom_range(0, ONE));
          else v = int'($urandom_range(0, ONE)) - ONE / 2;
          sys.push_back(mk_req(ACT_MATRIX, i, j, v, 0));
        end
        v = wild ? int'($urandom) : int'($urandom_range(0, 16 * ONE)) - 8 * ONE;
        sys.push_back(mk_req(ACT_RHS, i, $urandom_range(0, 15), v, 0));
      end
      // Harmless noise: upper-triangle and out-of-order entries beyond the order.
      repeat ($urandom_range(0, 3)) begin
        pick = $urandom_range(0, 15);
        if (pick < N_MAX - 1 && $urandom_range(0, 1) == 0)
          tmp = mk_req(ACT_MATRIX, pick, $urandom_range(pick + 1, 15), int'($urandom), 0);
        else if (n < N_MAX)
          tmp = mk_req($urandom_range(0, 1), $urandom_range(n, 15), $urandom_range(0, 15),
                       int'($urandom), 0);
        else
          tmp = mk_req(ACT_MATRIX, 0, $urandom_range(1, 15), int'($urandom), 0);
        sys.push_back(tmp);
      end
      for (int i = sys.size() - 1; i > 0; i--) begin
        pick = $urandom_range(0, i);
        tmp = sys[i];
        sys[i] = sys[pick];
        sys[pick] = tmp;
      end
      sys[sys.size() - 1].start_solve = 1'b1;
      foreach (sys[i]) send_request(sys[i]);
      sent += sys.size();
    end

    // Drain the remaining unknowns, then settle.
    start <= 1'b0;
    @(posedge clk);
    while (pending_x.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
